>>> sv/plac_pkg.sv
// Shared widths and stage counts for the point light attenuation core.
package plac_pkg;

    localparam int unsigned CoordW  = 24;              // Q12.12 coordinate
    localparam int unsigned CoefW   = 24;              // Q8.16 coefficient
    localparam int unsigned ChanW   = 8;               // colour channel
    localparam int unsigned OutW    = 16;              // Q8.8 result
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgW    = 24;

    localparam int unsigned AbsW    = CoordW + 1;      // |light - point|
    localparam int unsigned SqW     = 2 * AbsW;        // one squared axis
    localparam int unsigned SumW    = 50;              // sum of three squares
    localparam int unsigned RootW   = 25;              // isqrt of the sum
    localparam int unsigned D2W     = 38;              // d*d >> 12
    localparam int unsigned D2HalfW = D2W / 2;
    localparam int unsigned ProdW   = CoefW + D2HalfW; // coefficient times half of d2
    localparam int unsigned LinW    = CoefW + RootW;
    localparam int unsigned DenW    = 63;
    localparam int unsigned EW      = DenW + 8;        // 255 * den
    localparam int unsigned NumW    = ChanW + 36;      // channel << 36

    localparam int unsigned SqrtStages = RootW;
    localparam int unsigned DivStages  = OutW + 1;

    typedef enum logic [CfgIdxW-1:0] {
        REG_LIGHT_X   = 3'd0,
        REG_LIGHT_Y   = 3'd1,
        REG_LIGHT_Z   = 3'd2,
        REG_COLOR     = 3'd3,
        REG_ATT_CONST = 3'd4,
        REG_ATT_LIN   = 3'd5,
        REG_ATT_QUAD  = 3'd6,
        REG_AMBIENT   = 3'd7
    } t_cfg_idx;

    localparam logic [CoefW-1:0] AttLinReset = 24'd65536;

endpackage

>>> sv/plac_sqrt.sv
// Bit-per-stage integer square root pipeline.
module plac_sqrt (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [plac_pkg::SumW-1:0]    i_s,
    output logic [plac_pkg::RootW-1:0]   o_root
);
    import plac_pkg::*;

    localparam int unsigned RemW = SumW + 2;

    logic [RemW-1:0]  r_rem  [SqrtStages];
    logic [RootW-1:0] r_root [SqrtStages];

    for (genvar k = 0; k < SqrtStages; k++) begin : g_stage
        localparam int unsigned Bit = SqrtStages - 1 - k;
        logic [RemW-1:0]  w_rem_in;
        logic [RootW-1:0] w_root_in;
        logic [RemW-1:0]  w_trial;
        logic [RemW-1:0]  n_rem;
        logic [RootW-1:0] n_root;

        if (k == 0) begin : g_first
            assign w_rem_in  = RemW'(i_s);
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
        end

        // Trial value (2*root + 2^bit) * 2^bit
        assign w_trial = (RemW'(w_root_in) << (Bit + 1)) + (RemW'(1) << (2 * Bit));

        always_comb begin
            if (w_rem_in >= w_trial) begin
                n_rem  = w_rem_in - w_trial;
                n_root = w_root_in | (RootW'(1) << Bit);
            end else begin
                n_rem  = w_rem_in;
                n_root = w_root_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
            end
        end
    end

    assign o_root = r_root[SqrtStages-1];

endmodule

>>> sv/plac_div.sv
// Restoring divider pipeline: channel * 2^36 / e, 16 quotient bits with overflow.
module plac_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [plac_pkg::ChanW-1:0]  i_ch,
    input  logic [plac_pkg::EW-1:0]     i_e,
    output logic [plac_pkg::OutW-1:0]   o_q,
    output logic                        o_ovf
);
    import plac_pkg::*;

    localparam int unsigned CmpW = EW + OutW;

    logic [NumW-1:0] r_rem [DivStages];
    logic [EW-1:0]   r_e   [DivStages];
    logic [OutW-1:0] r_q   [DivStages];
    logic            r_ovf [DivStages];

    // Quotient reaches 2^16 exactly when ch * 2^20 >= e
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {i_ch, 36'd0};
            r_e[0]   <= i_e;
            r_q[0]   <= '0;
            r_ovf[0] <= (EW'({i_ch, 20'd0}) >= i_e);
        end
    end

    for (genvar g = 1; g < DivStages; g++) begin : g_stage
        localparam int unsigned Bit = DivStages - 1 - g;
        logic [CmpW-1:0] w_sub;
        logic            w_take;

        assign w_sub  = CmpW'(r_e[g-1]) << Bit;
        assign w_take = CmpW'(r_rem[g-1]) >= w_sub;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= w_take ? NumW'(CmpW'(r_rem[g-1]) - w_sub) : r_rem[g-1];
                r_q[g]   <= w_take ? (r_q[g-1] | (OutW'(1) << Bit)) : r_q[g-1];
                r_e[g]   <= r_e[g-1];
                r_ovf[g] <= r_ovf[g-1];
            end
        end
    end

    assign o_q   = r_q[DivStages-1];
    assign o_ovf = r_ovf[DivStages-1];

endmodule

>>> sv/point_light_attenuation_core.sv
// Point light attenuation core: light colour at a query point, attenuated by distance.
//
// Input channel (i_valid / o_ready) carries one query point per transaction,
// signed Q12.12. Output channel (o_valid / i_ready) carries the attenuated
// red, green and blue in Q8.8 plus a clip flag, one result per point, in order.
// Configuration registers are written through i_cfg_we / i_cfg_idx / i_cfg_data
// and must only change while no transaction is in flight.
// The pipeline has 50 register stages: 3 of difference, square and sum,
// 25 of square root (one root bit each), 4 forming the denominator, 17 of
// restoring division (an overflow check, then one quotient bit each) and
// the output register.
// Throughput is one point per cycle unless the receiver stalls; every stage
// is a register, so a new transaction enters each cycle while earlier ones advance.
// Reset (synchronous, active low) empties the pipeline and returns the
// registers to their defaults (linear term 1.0, all others zero).
// When the receiver stalls with a result waiting, the whole pipeline holds;
// o_ready drops, and no data is lost or repeated.
module point_light_attenuation_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [plac_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [plac_pkg::CfgW-1:0]         i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [plac_pkg::CoordW-1:0] i_point_x,
    input  logic signed [plac_pkg::CoordW-1:0] i_point_y,
    input  logic signed [plac_pkg::CoordW-1:0] i_point_z,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [plac_pkg::OutW-1:0]         o_lit_red,
    output logic [plac_pkg::OutW-1:0]         o_lit_green,
    output logic [plac_pkg::OutW-1:0]         o_lit_blue,
    output logic                              o_clipped
);
    import plac_pkg::*;

    localparam int unsigned Lat   = 3 + SqrtStages + 4 + DivStages + 1;
    localparam int unsigned SqEnd = 3 + SqrtStages;

    // Configuration registers
    logic signed [CoordW-1:0] r_light_x, r_light_y, r_light_z;
    logic [CfgW-1:0]          r_color;
    logic [CoefW-1:0]         r_att_const, r_att_lin, r_att_quad;
    logic                     r_ambient;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_x   <= '0;
            r_light_y   <= '0;
            r_light_z   <= '0;
            r_color     <= '0;
            r_att_const <= '0;
            r_att_lin   <= AttLinReset;
            r_att_quad  <= '0;
            r_ambient   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_LIGHT_X:   r_light_x   <= i_cfg_data;
                REG_LIGHT_Y:   r_light_y   <= i_cfg_data;
                REG_LIGHT_Z:   r_light_z   <= i_cfg_data;
                REG_COLOR:     r_color     <= i_cfg_data;
                REG_ATT_CONST: r_att_const <= i_cfg_data;
                REG_ATT_LIN:   r_att_lin   <= i_cfg_data;
                REG_ATT_QUAD:  r_att_quad  <= i_cfg_data;
                REG_AMBIENT:   r_ambient   <= i_cfg_data[0];
                default:       r_ambient   <= r_ambient;
            endcase
        end
    end

    logic [ChanW-1:0] w_ch [3];
    assign w_ch[0] = r_color[23:16];
    assign w_ch[1] = r_color[15:8];
    assign w_ch[2] = r_color[7:0];

    // Global advance: move everything whenever the output slot frees up
    logic           w_en;
    logic [Lat-1:0] r_vld;

    assign w_en    = !r_vld[Lat-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[Lat-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[Lat-2:0], i_valid};
        end
    end

    // Stage 1: absolute axis differences
    logic signed [AbsW-1:0] w_dx, w_dy, w_dz;
    logic [AbsW-1:0]        r_ax, r_ay, r_az;

    assign w_dx = {r_light_x[CoordW-1], r_light_x} - {i_point_x[CoordW-1], i_point_x};
    assign w_dy = {r_light_y[CoordW-1], r_light_y} - {i_point_y[CoordW-1], i_point_y};
    assign w_dz = {r_light_z[CoordW-1], r_light_z} - {i_point_z[CoordW-1], i_point_z};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ax <= w_dx[AbsW-1] ? AbsW'(-w_dx) : AbsW'(w_dx);
            r_ay <= w_dy[AbsW-1] ? AbsW'(-w_dy) : AbsW'(w_dy);
            r_az <= w_dz[AbsW-1] ? AbsW'(-w_dz) : AbsW'(w_dz);
        end
    end

    // Stage 2: squares; stage 3: sum
    logic [SqW-1:0]  r_sx, r_sy, r_sz;
    logic [SumW-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sx  <= r_ax * r_ax;
            r_sy  <= r_ay * r_ay;
            r_sz  <= r_az * r_az;
            r_sum <= SumW'(r_sx) + SumW'(r_sy) + SumW'(r_sz);
        end
    end

    logic [RootW-1:0] w_root;

    plac_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_s    (r_sum),
        .o_root (w_root)
    );

    // Denominator: clamp distance, square, split quadratic product, sum, scale by 255
    logic [RootW-1:0]   w_d;
    logic [2*RootW-1:0] w_dd;
    logic [D2W-1:0]     r_d2;
    logic [LinW-1:0]    r_lin, r_lin2;
    logic [ProdW-1:0]   r_qlo, r_qhi;
    logic [DenW-1:0]    r_den;
    logic [EW-1:0]      r_e;

    assign w_d  = (w_root == '0) ? RootW'(1) : w_root;
    assign w_dd = w_d * w_d;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2   <= w_dd[2*RootW-1:12];
            r_lin  <= r_att_lin * w_d;
            r_qlo  <= r_att_quad * r_d2[D2HalfW-1:0];
            r_qhi  <= r_att_quad * r_d2[D2W-1:D2HalfW];
            r_lin2 <= r_lin;
            r_den  <= (DenW'(r_qhi) << D2HalfW) + DenW'(r_qlo) + DenW'(r_lin2)
                    + (DenW'(r_att_const) << 12);
            r_e    <= (EW'(r_den) << 8) - EW'(r_den);
        end
    end

    // One divider per channel
    logic [OutW-1:0] w_q   [3];
    logic            w_ovf [3];

    for (genvar c = 0; c < 3; c++) begin : g_chan
        plac_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_ch  (w_ch[c]),
            .i_e   (r_e),
            .o_q   (w_q[c]),
            .o_ovf (w_ovf[c])
        );
    end

    // Output register: ambient bypass or saturated quotient
    logic [OutW-1:0] n_lit [3];
    logic            n_clipped;
    logic [OutW-1:0] r_lit [3];
    logic            r_clipped;

    always_comb begin
        n_clipped = 1'b0;
        for (int c = 0; c < 3; c++) begin
            if (r_ambient) begin
                n_lit[c] = OutW'(w_ch[c]) + OutW'(w_ch[c] == '1);
            end else if (w_ovf[c]) begin
                n_lit[c]  = '1;
                n_clipped = 1'b1;
            end else begin
                n_lit[c] = w_q[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lit     <= n_lit;
            r_clipped <= n_clipped;
        end
    end

    assign o_lit_red   = r_lit[0];
    assign o_lit_green = r_lit[1];
    assign o_lit_blue  = r_lit[2];
    assign o_clipped   = r_clipped;

    // Ambient results never report clipping
    a_ambient_noclip : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_ambient) |-> !o_clipped)
        else $error("clip raised in ambient mode");

    // A clip flag comes with at least one saturated channel
    a_clip_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clipped) |->
        (o_lit_red == '1 || o_lit_green == '1 || o_lit_blue == '1))
        else $error("clip without a saturated channel");

    // A stall freezes the valid bit of the first denominator stage, just after the root pipeline
    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && $past(i_rst_n)) |=> $stable(r_vld[SqEnd]))
        else $error("pipeline moved during a stall");

endmodule
